@@ rtl/core/ave_pkg.sv @@
// ----------------------------------------------------------------------------
// ADSR volume envelope package
// Shared types, register indexes and arithmetic constants of the envelope.
// ----------------------------------------------------------------------------
package ave_pkg;

   localparam int ADDR_W      = 4;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;
   localparam int FRONT_DEPTH = 3;
   localparam int QUO_W       = 8;
   localparam int NUM_W       = 24;
   localparam int DEN_W       = 16;
   localparam int SUS_RECIP   = 33027;
   localparam int SUS_SHIFT   = 22;
   localparam int SUS_DIV_LOG = 7;

   localparam logic [1:0] REG_ATTACK  = 2'd0;
   localparam logic [1:0] REG_DECAY   = 2'd1;
   localparam logic [1:0] REG_SUSTAIN = 2'd2;
   localparam logic [1:0] REG_RELEASE = 2'd3;

   localparam logic [7:0] SUSTAIN_RESET = 8'd127;

   typedef enum logic [2:0] {
      PH_ATTACK,
      PH_DECAY,
      PH_SUSTAIN,
      PH_RELEASE,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0]         base_volume;
      logic [30:0]        elapsed_ms;
      logic signed [31:0] note_length;
   } req_type;

   typedef struct packed {
      logic [7:0] volume;
      logic       releasing;
      logic       finished;
   } rsp_type;

   typedef struct packed {
      logic [15:0] attack_ms;
      logic [15:0] decay_ms;
      logic [7:0]  sustain_level;
      logic [15:0] release_ms;
   } cfg_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [7:0]       from;
      logic             neg;
      logic             releasing;
      logic             finished;
   } work_type;

   typedef struct packed {
      logic empty;
      logic almost_full;
   } queue_status_type;

endpackage

@@ rtl/core/ave_front.sv @@
// ----------------------------------------------------------------------------
// ADSR envelope front end
// Computes the sustain level, picks the envelope phase and forms the
// interpolation numerator and divisor for each accepted query.
// ----------------------------------------------------------------------------
module ave_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  ave_pkg::req_type  req_data,
   input  ave_pkg::cfg_type  cfg,
   output logic              push,
   output ave_pkg::work_type work
);
   import ave_pkg::*;

   logic             v1_ff, v2_ff, v3_ff;
   req_type          req1_ff;
   logic [15:0]      prod1_ff;
   logic [15:0]      prod1_in;

   logic [31:0]      prod2_ff, prod2_in;
   logic [15:0]      x2_ff;
   logic [7:0]       base2_ff;
   phase_type        phase2_ff, phase2_in;
   logic [15:0]      pos2_ff, pos2_in;
   logic             rel2_ff, rel2_in, fin2_ff, fin2_in;

   logic [7:0]       sus3_ff, sus3_in;
   logic [7:0]       base3_ff;
   phase_type        phase3_ff;
   logic [15:0]      pos3_ff;
   logic             rel3_ff, fin3_ff;

   logic [31:0]      t_val, ad_val, len_val, eff_val;
   logic [32:0]      effr_val;
   logic [31:0]      pos_wide;
   logic             endless;

   logic [9:0]       q0;
   logic [16:0]      q0_times;

   logic [7:0]       mag, from_val;
   logic             neg_val;
   logic [15:0]      den_val;

   assign prod1_in = 16'(req_data.base_volume) * 16'(cfg.sustain_level);
   assign prod2_in = 32'(prod1_ff) * 32'(SUS_RECIP);

   always_comb begin
      t_val    = {1'b0, req1_ff.elapsed_ms};
      ad_val   = 32'(cfg.attack_ms) + 32'(cfg.decay_ms);
      endless  = req1_ff.note_length[31];
      len_val  = {1'b0, req1_ff.note_length[30:0]};
      eff_val  = (!endless && (len_val > ad_val)) ? len_val : ad_val;
      effr_val = {1'b0, eff_val} + 33'(cfg.release_ms);
      pos_wide = 32'd0;
      if (t_val < 32'(cfg.attack_ms)) begin
         phase2_in = PH_ATTACK;
         pos_wide  = t_val;
      end else if (t_val < ad_val) begin
         phase2_in = PH_DECAY;
         pos_wide  = t_val - 32'(cfg.attack_ms);
      end else if (endless || (t_val < eff_val)) begin
         phase2_in = PH_SUSTAIN;
      end else if ({1'b0, t_val} < effr_val) begin
         phase2_in = PH_RELEASE;
         pos_wide  = t_val - eff_val;
      end else begin
         phase2_in = PH_DONE;
      end
      pos2_in = pos_wide[15:0];
      rel2_in = !endless && (t_val >= eff_val);
      fin2_in = !endless && ({1'b0, t_val} >= effr_val);
   end

   always_comb begin
      q0       = prod2_ff[SUS_SHIFT +: 10];
      q0_times = (17'(q0) << SUS_DIV_LOG) - 17'(q0);
      if (q0_times > 17'(x2_ff)) begin
         sus3_in = 8'(q0 - 10'd1);
      end else begin
         sus3_in = q0[7:0];
      end
   end

   always_comb begin
      unique case (phase3_ff)
         PH_ATTACK: begin
            mag = base3_ff; from_val = 8'd0; neg_val = 1'b0; den_val = cfg.attack_ms;
         end
         PH_DECAY: begin
            neg_val  = sus3_ff < base3_ff;
            mag      = neg_val ? (base3_ff - sus3_ff) : (sus3_ff - base3_ff);
            from_val = base3_ff;
            den_val  = cfg.decay_ms;
         end
         PH_RELEASE: begin
            mag = sus3_ff; from_val = sus3_ff; neg_val = 1'b1; den_val = cfg.release_ms;
         end
         PH_SUSTAIN: begin
            mag = 8'd0; from_val = sus3_ff; neg_val = 1'b0; den_val = 16'd1;
         end
         default: begin
            mag = 8'd0; from_val = 8'd0; neg_val = 1'b0; den_val = 16'd1;
         end
      endcase
      work.num       = NUM_W'(pos3_ff) * NUM_W'(mag);
      work.den       = den_val;
      work.from      = from_val;
      work.neg       = neg_val;
      work.releasing = rel3_ff;
      work.finished  = fin3_ff;
   end

   assign push = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      req1_ff   <= req_data;
      prod1_ff  <= prod1_in;
      prod2_ff  <= prod2_in;
      x2_ff     <= prod1_ff;
      base2_ff  <= req1_ff.base_volume;
      phase2_ff <= phase2_in;
      pos2_ff   <= pos2_in;
      rel2_ff   <= rel2_in;
      fin2_ff   <= fin2_in;
      sus3_ff   <= sus3_in;
      base3_ff  <= base2_ff;
      phase3_ff <= phase2_ff;
      pos3_ff   <= pos2_ff;
      rel3_ff   <= rel2_ff;
      fin3_ff   <= fin2_ff;
   end

endmodule

@@ rtl/core/ave_queue.sv @@
// ----------------------------------------------------------------------------
// ADSR envelope work queue
// Short first-in first-out buffer between the front end and the divider.
// ----------------------------------------------------------------------------
module ave_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ave_pkg::work_type         wdata,
   input  logic                      pop,
   output ave_pkg::work_type         rdata,
   output ave_pkg::queue_status_type status
);
   import ave_pkg::*;

   work_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign rdata              = mem_ff[rd_ptr_ff];
   assign status.empty       = (count_ff == '0);
   assign status.almost_full = (count_ff > QCNT_W'(QUEUE_DEPTH - FRONT_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/core/ave_back.sv @@
// ----------------------------------------------------------------------------
// ADSR envelope back end
// Pipelined restoring divider, one quotient bit per stage, followed by the
// final offset and the registered result.
// ----------------------------------------------------------------------------
module ave_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ave_pkg::work_type work,
   output logic              rsp_valid,
   output ave_pkg::rsp_type  rsp_data
);
   import ave_pkg::*;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic [7:0]       from;
      logic             neg;
      logic             releasing;
      logic             finished;
   } stage_type;

   stage_type  st_ff [QUO_W];
   stage_type  st_in [QUO_W];
   logic       v_ff  [QUO_W];
   stage_type  src;
   logic [NUM_W-1:0] dsh;

   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;

   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         if (k == 0) begin
            src.rem       = work.num;
            src.den       = work.den;
            src.quo       = '0;
            src.from      = work.from;
            src.neg       = work.neg;
            src.releasing = work.releasing;
            src.finished  = work.finished;
         end else begin
            src = st_ff[k-1];
         end
         dsh      = NUM_W'(src.den) << (QUO_W - 1 - k);
         st_in[k] = src;
         if (src.rem >= dsh) begin
            st_in[k].rem              = src.rem - dsh;
            st_in[k].quo[QUO_W-1-k]   = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in.volume    = st_ff[QUO_W-1].neg ? st_ff[QUO_W-1].from - st_ff[QUO_W-1].quo
                                            : st_ff[QUO_W-1].from + st_ff[QUO_W-1].quo;
      rsp_in.releasing = st_ff[QUO_W-1].releasing;
      rsp_in.finished  = st_ff[QUO_W-1].finished;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            v_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < QUO_W; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         rsp_valid_ff <= v_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_W; k++) begin
         st_ff[k] <= st_in[k];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/adsr_volume_envelope.sv @@
// ----------------------------------------------------------------------------
// ADSR volume envelope
// Stateless envelope evaluator: attack, decay, sustain and release volume
// for one query per transfer, with releasing and finished flags.
// ----------------------------------------------------------------------------
// Channel   Ports                                    Transfer
// query     start, busy, req_data                    start high, busy low
// result    rsp_valid, rsp_data                      one cycle, rsp_valid
// config    psel, penable, pwrite, paddr, pwdata,    psel, penable, pwrite
//           prdata, pready
//
// A query may be started every cycle while busy is low.
// Each result passes through the three front stages, the queue,
// the eight-stage divider and the output register.
// Reset clears all pipeline valid bits and restores the register defaults.
// The result side cannot stall, so busy stays low in normal operation.
// ----------------------------------------------------------------------------
module adsr_volume_envelope (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  ave_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output ave_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ave_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import ave_pkg::*;

   cfg_type          cfg_ff;
   logic             cfg_wr;
   logic [1:0]       reg_idx;
   logic             accept;
   logic             push;
   work_type         work_front, work_queue;
   queue_status_type qstat;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign cfg_wr  = psel && penable && pwrite;
   assign accept  = start && !busy;
   assign busy    = qstat.almost_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_ms     <= '0;
         cfg_ff.decay_ms      <= '0;
         cfg_ff.sustain_level <= SUSTAIN_RESET;
         cfg_ff.release_ms    <= '0;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            REG_ATTACK:  cfg_ff.attack_ms     <= pwdata[15:0];
            REG_DECAY:   cfg_ff.decay_ms      <= pwdata[15:0];
            REG_SUSTAIN: cfg_ff.sustain_level <= pwdata[7:0];
            REG_RELEASE: cfg_ff.release_ms    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ATTACK:  prdata = 32'(cfg_ff.attack_ms);
         REG_DECAY:   prdata = 32'(cfg_ff.decay_ms);
         REG_SUSTAIN: prdata = 32'(cfg_ff.sustain_level);
         REG_RELEASE: prdata = 32'(cfg_ff.release_ms);
         default:     prdata = '0;
      endcase
   end

   ave_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .push     (push),
      .work     (work_front)
   );

   ave_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (work_front),
      .pop    (!qstat.empty),
      .rdata  (work_queue),
      .status (qstat)
   );

   ave_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!qstat.empty),
      .work      (work_queue),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_fin_implies_rel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.finished || rsp_data.releasing))
      else $error("finished without releasing");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##13 rsp_valid)
      else $error("result missing after query");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 13))
      else $error("result without query");

endmodule
